// ===== rtl/tlik_pkg.sv =====
// shared types, constants and the cordic angle table for the two-link arm solver
// no dependencies
package tlik_pkg;

  localparam int CordicSteps = 20;
  localparam int CordicIdxW = 5;

  typedef enum logic [1:0] {
    REQ_SOLVE  = 2'd0,
    REQ_COMMIT = 2'd1,
    REQ_LOAD   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    CFG_UPPER_LEN   = 3'd0,
    CFG_FORE_LEN    = 3'd1,
    CFG_UPPER_RATIO = 3'd2,
    CFG_FORE_RATIO  = 3'd3,
    CFG_LIFT_RATIO  = 3'd4,
    CFG_HEIGHT_MIN  = 3'd5,
    CFG_HEIGHT_MAX  = 3'd6,
    CFG_UNUSED      = 3'd7
  } cfg_idx_t;

  // 90 degrees in 1/65536 deg
  localparam logic signed [27:0] QuarterTurn = 28'sd5898240;
  // 90 degrees in 1/256 deg
  localparam logic signed [17:0] QuarterDeg = 18'sd23040;

  // cordic vector word: inputs up to about 2^60, growth 1.65
  localparam int VecW = 64;

  typedef struct packed {
    logic start;
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
  } cordic_req_t;

  typedef struct packed {
    logic done;
    logic signed [17:0] angle;
  } cordic_rsp_t;

  function automatic logic [22:0] atan_entry(input logic [CordicIdxW-1:0] i);
    logic [22:0] r;
    case (i)
      5'd0: r = 23'd2949120;
      5'd1: r = 23'd1740967;
      5'd2: r = 23'd919879;
      5'd3: r = 23'd466945;
      5'd4: r = 23'd234379;
      5'd5: r = 23'd117304;
      5'd6: r = 23'd58666;
      5'd7: r = 23'd29335;
      5'd8: r = 23'd14668;
      5'd9: r = 23'd7334;
      5'd10: r = 23'd3667;
      5'd11: r = 23'd1833;
      5'd12: r = 23'd917;
      5'd13: r = 23'd458;
      5'd14: r = 23'd229;
      5'd15: r = 23'd115;
      5'd16: r = 23'd57;
      5'd17: r = 23'd29;
      5'd18: r = 23'd14;
      5'd19: r = 23'd7;
      default: r = 23'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/tlik_cordic.sv =====
// vectoring cordic, one micro-rotation per cycle, angle in 1/256 deg rounded
// depends on tlik_pkg
module tlik_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  tlik_pkg::cordic_req_t req,
  output tlik_pkg::cordic_rsp_t rsp
);
  import tlik_pkg::*;

  logic signed [VecW:0] x_r, y_r;
  logic signed [27:0] z_r;
  logic [CordicIdxW-1:0] i_r;
  logic busy_r, done_r;
  logic signed [VecW:0] dx, dy;
  logic signed [27:0] tab;
  logic signed [27:0] zr;
  logic signed [27:0] za;
  logic [19:0] zq;

  assign dx = y_r >>> i_r;
  assign dy = x_r >>> i_r;
  assign tab = 28'(signed'({1'b0, atan_entry(i_r)}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && i_r == 5'(CordicSteps - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      i_r <= '0;
      if (req.x < 0) begin
        x_r <= (VecW+1)'(req.y);
        y_r <= -(VecW+1)'(req.x);
        z_r <= QuarterTurn;
      end else begin
        x_r <= (VecW+1)'(req.x);
        y_r <= (VecW+1)'(req.y);
        z_r <= '0;
      end
    end else if (busy_r) begin
      i_r <= i_r + 5'd1;
      if (!y_r[VecW]) begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + tab;
      end else begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - tab;
      end
    end
  end

  // round half away from zero
  assign za = z_r[27] ? -z_r : z_r;
  assign zr = za + 28'sd128;
  assign zq = zr[27:8];

  always_comb begin
    rsp.done = done_r;
    rsp.angle = z_r[27] ? -18'(signed'(zq)) : 18'(signed'(zq));
  end

endmodule

// ===== rtl/tlik_isqrt.sv =====
// bit-pair floor square root, one result bit per cycle
// depends on tlik_pkg
module tlik_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [61:0] radicand,
  output logic        done,
  output logic [30:0] root
);
  import tlik_pkg::*;

  logic [61:0] rem_r;
  logic [63:0] n_r;
  logic [30:0] q_r;
  logic [4:0] cnt_r;
  logic busy_r, done_r;
  logic [33:0] trial;
  logic [33:0] rem_sh;

  assign rem_sh = {rem_r[31:0], n_r[63:62]};
  assign trial = {1'b0, q_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 5'd31) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r <= {2'b00, radicand};
      rem_r <= '0;
      q_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 5'd1;
      n_r <= {n_r[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r <= 62'(rem_sh - trial);
        q_r <= {q_r[29:0], 1'b1};
      end else begin
        rem_r <= 62'(rem_sh);
        q_r <= {q_r[29:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign root = q_r;

endmodule

// ===== rtl/two_link_planar_ik_steps.sv =====
// channel | dir | beat contents
// in_     | in  | req_type, pos_x, pos_y, pos_z
// out_    | out | reachable, targets, step deltas, committed
// cfg_    | in  | cfg_index, cfg_data
// a reachable solve runs the squares, the reach check, two 32-step square roots and
// three 20-step cordic passes on the shared rotator, then the goal and step products
// an unreachable solve ends at the reach check; commit, load and unused codes skip the solve
// the result waits in the output register; a new command is taken after it leaves
// reset synchronous active low; depends on tlik_pkg, tlik_cordic, tlik_isqrt
module two_link_planar_ik_steps (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_req_type,
  input  logic signed [19:0]  in_pos_x,
  input  logic signed [19:0]  in_pos_y,
  input  logic signed [19:0]  in_pos_z,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_reachable,
  output logic signed [17:0]  out_upper_target,
  output logic signed [17:0]  out_fore_target,
  output logic signed [31:0]  out_upper_steps,
  output logic signed [31:0]  out_fore_steps,
  output logic signed [31:0]  out_lift_steps,
  output logic                out_committed,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_data
);
  import tlik_pkg::*;

  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_SQ    = 14'b00000000000010,
    ST_SUM   = 14'b00000000000100,
    ST_CHK   = 14'b00000000001000,
    ST_SQRT  = 14'b00000000010000,
    ST_HMUL  = 14'b00000000100000,
    ST_CX    = 14'b00000001000000,
    ST_CA    = 14'b00000010000000,
    ST_CB    = 14'b00000100000000,
    ST_GOAL  = 14'b00001000000000,
    ST_MULU  = 14'b00010000000000,
    ST_MULF  = 14'b00100000000000,
    ST_MULH  = 14'b01000000000000,
    ST_OUT   = 14'b10000000000000
  } state_t;

  state_t state_r;
  logic [1:0] sub_r;

  logic [18:0] alen_r, blen_r;
  logic [23:0] uratio_r, fratio_r, lratio_r;
  logic signed [19:0] hmin_r, hmax_r;

  logic signed [17:0] ucur_r, fcur_r, ugoal_r, fgoal_r;
  logic signed [19:0] hcur_r, hgoal_r;
  logic reach_r;

  logic signed [19:0] x_r, y_r, z_r;

  // work registers
  logic [40:0] s_r, aa_r, bb_r, lo_r, hi_r;
  logic signed [17:0] cx_r, ca_r, cb_r;
  logic [61:0] h_r;
  logic [30:0] ru_r;
  logic sq_phase_r;
  logic cx_triv_r;
  logic signed [31:0] su_r, sf_r, sh_r;
  logic commit_r;

  // shared multiplier, one product a cycle
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  assign mp = ma * mb;

  cordic_req_t creq;
  cordic_rsp_t crsp;
  tlik_cordic u_cordic (.clk(clk), .rst_n(rst_n), .req(creq), .rsp(crsp));

  logic sq_start, sq_done;
  logic [61:0] sq_in;
  logic [30:0] sq_root;
  tlik_isqrt u_isqrt (.clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(sq_in),
    .done(sq_done), .root(sq_root));

  logic in_fire, out_fire;
  assign in_ready = (state_r == ST_IDLE);
  assign in_fire = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign out_valid = (state_r == ST_OUT);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alen_r <= '0;
      blen_r <= '0;
      uratio_r <= 24'd256;
      fratio_r <= 24'd256;
      lratio_r <= 24'd256;
      hmin_r <= '0;
      hmax_r <= 20'sd524287;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_UPPER_LEN:   alen_r <= cfg_data[18:0];
        CFG_FORE_LEN:    blen_r <= cfg_data[18:0];
        CFG_UPPER_RATIO: uratio_r <= cfg_data;
        CFG_FORE_RATIO:  fratio_r <= cfg_data;
        CFG_LIFT_RATIO:  lratio_r <= cfg_data;
        CFG_HEIGHT_MIN:  hmin_r <= cfg_data[19:0];
        CFG_HEIGHT_MAX:  hmax_r <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // multiplier operand selection
  logic signed [41:0] du, df, dh;
  logic hin;
  assign du = 42'(ugoal_r) - 42'(ucur_r);
  assign df = 42'(fgoal_r) - 42'(fcur_r);
  assign hin = (z_r >= hmin_r) && (z_r <= hmax_r);
  assign dh = hin ? 42'(z_r) - 42'(hcur_r) : '0;

  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      ST_SQ: begin
        case (sub_r)
          2'd0: begin ma = 33'(x_r); mb = 33'(x_r); end
          2'd1: begin ma = 33'(y_r); mb = 33'(y_r); end
          2'd2: begin ma = 33'(signed'({1'b0, alen_r})); mb = ma; end
          default: begin ma = 33'(signed'({1'b0, blen_r})); mb = ma; end
        endcase
      end
      ST_SUM: begin
        if (sub_r[0]) begin
          ma = 33'(signed'({1'b0, alen_r})) + 33'(signed'({1'b0, blen_r}));
        end else begin
          ma = 33'(signed'({1'b0, alen_r})) - 33'(signed'({1'b0, blen_r}));
        end
        mb = ma;
      end
      ST_HMUL: begin
        ma = 33'(signed'({1'b0, ru_r}));
        mb = 33'(signed'({1'b0, sq_root}));
      end
      ST_MULU: begin ma = 33'(du); mb = 33'(signed'({1'b0, uratio_r})); end
      ST_MULF: begin ma = 33'(df); mb = 33'(signed'({1'b0, fratio_r})); end
      ST_MULH: begin ma = 33'(dh); mb = 33'(signed'({1'b0, lratio_r})); end
      default: ;
    endcase
  end

  // truncating shift and 32-bit saturation
  function automatic logic signed [31:0] div_sat(input logic signed [65:0] p,
                                                 input logic [4:0] sh);
    logic signed [65:0] q;
    logic signed [65:0] bias;
    bias = p[65] ? ((66'sd1 <<< sh) - 66'sd1) : 66'sd0;
    q = (p + bias) >>> sh;
    if (q > 66'sd2147483647) return 32'sh7fffffff;
    if (q < -66'sd2147483648) return 32'sh80000000;
    return q[31:0];
  endfunction

  logic signed [63:0] ca_x, cb_x, sx_abs, sy_sgn;
  assign ca_x = 64'(signed'({1'b0, aa_r})) + 64'(signed'({1'b0, s_r}))
              - 64'(signed'({1'b0, bb_r}));
  assign cb_x = 64'(signed'({1'b0, s_r})) + 64'(signed'({1'b0, bb_r}))
              - 64'(signed'({1'b0, aa_r}));
  assign sx_abs = x_r[19] ? -64'(x_r) : 64'(x_r);
  assign sy_sgn = x_r[19] ? -64'(y_r) : 64'(y_r);

  logic reach_ok;
  assign reach_ok = (alen_r != 0) && (blen_r != 0) && (s_r != 0)
                 && (s_r >= lo_r) && (s_r <= hi_r);

  always_comb begin
    creq.start = 1'b0;
    creq.x = '0;
    creq.y = '0;
    sq_start = 1'b0;
    sq_in = '0;
    case (state_r)
      ST_CHK: begin
        sq_start = reach_ok;
        sq_in = {3'b0, hi_r - s_r, 18'b0};
      end
      ST_SQRT: begin
        sq_start = sq_done && !sq_phase_r;
        sq_in = {3'b0, s_r - lo_r, 18'b0};
      end
      ST_HMUL: begin
        creq.start = 1'b1;
        creq.x = sx_abs <<< 38;
        creq.y = sy_sgn <<< 38;
      end
      ST_CX: begin
        creq.start = crsp.done;
        creq.x = ca_x <<< 18;
        creq.y = 64'(h_r);
      end
      ST_CA: begin
        creq.start = crsp.done;
        creq.x = cb_x <<< 18;
        creq.y = 64'(h_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: if (in_fire) begin
        x_r <= in_pos_x;
        y_r <= in_pos_y;
        z_r <= in_pos_z;
        su_r <= '0;
        sf_r <= '0;
        sh_r <= '0;
        commit_r <= (req_t'(in_req_type) == REQ_COMMIT) && reach_r;
      end
      ST_SQ: begin
        case (sub_r)
          2'd0: s_r <= 41'(mp);
          2'd1: s_r <= s_r + 41'(mp);
          2'd2: aa_r <= 41'(mp);
          default: bb_r <= 41'(mp);
        endcase
      end
      ST_SUM: begin
        if (sub_r == 2'd0) begin
          lo_r <= 41'(mp);
        end else begin
          hi_r <= 41'(mp);
        end
      end
      ST_CHK: begin
        sq_phase_r <= 1'b0;
        cx_triv_r <= (x_r == 0);
      end
      ST_SQRT: if (sq_done && !sq_phase_r) begin
        ru_r <= sq_root;
        sq_phase_r <= 1'b1;
      end
      ST_HMUL: h_r <= 62'(mp);
      ST_CX: if (crsp.done) begin
        cx_r <= cx_triv_r ? (y_r > 0 ? QuarterDeg : -QuarterDeg) : crsp.angle;
      end
      ST_CA: if (crsp.done) ca_r <= crsp.angle;
      ST_CB: if (crsp.done) cb_r <= crsp.angle;
      ST_MULU: su_r <= div_sat(mp, 5'd16);
      ST_MULF: sf_r <= div_sat(mp, 5'd16);
      ST_MULH: sh_r <= div_sat(mp, 5'd12);
      default: ;
    endcase
  end

  logic signed [17:0] ca_s, cb_s;
  assign ca_s = (y_r <= 0) ? -ca_r : ca_r;
  assign cb_s = (y_r <= 0) ? -cb_r : cb_r;

  function automatic logic signed [17:0] sat18(input logic signed [19:0] v);
    if (v > 20'sd131071) return 18'sh1ffff;
    if (v < -20'sd131072) return 18'sh20000;
    return v[17:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sub_r <= '0;
      ucur_r <= '0;
      fcur_r <= '0;
      hcur_r <= '0;
      ugoal_r <= '0;
      fgoal_r <= '0;
      hgoal_r <= '0;
      reach_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: if (in_fire) begin
          sub_r <= '0;
          case (req_t'(in_req_type))
            REQ_SOLVE: state_r <= ST_SQ;
            REQ_COMMIT: begin
              if (reach_r) begin
                ucur_r <= ugoal_r;
                fcur_r <= fgoal_r;
                hcur_r <= hgoal_r;
                reach_r <= 1'b0;
              end
              state_r <= ST_OUT;
            end
            REQ_LOAD: begin
              ucur_r <= sat18(in_pos_x);
              fcur_r <= sat18(in_pos_y);
              hcur_r <= in_pos_z;
              ugoal_r <= '0;
              fgoal_r <= '0;
              hgoal_r <= '0;
              state_r <= ST_OUT;
            end
            default: state_r <= ST_OUT;
          endcase
        end
        ST_SQ: begin
          sub_r <= sub_r + 2'd1;
          if (sub_r == 2'd3) state_r <= ST_SUM;
        end
        ST_SUM: begin
          sub_r <= sub_r + 2'd1;
          if (sub_r == 2'd1) state_r <= ST_CHK;
        end
        ST_CHK: begin
          if (reach_ok) begin
            state_r <= ST_SQRT;
          end else begin
            reach_r <= 1'b0;
            state_r <= ST_OUT;
          end
        end
        ST_SQRT: if (sq_done && sq_phase_r) state_r <= ST_HMUL;
        ST_HMUL: state_r <= ST_CX;
        ST_CX: if (crsp.done) state_r <= ST_CA;
        ST_CA: if (crsp.done) state_r <= ST_CB;
        ST_CB: if (crsp.done) state_r <= ST_GOAL;
        ST_GOAL: begin
          ugoal_r <= cx_r - ca_s;
          fgoal_r <= cx_r + cb_s;
          hgoal_r <= z_r;
          reach_r <= 1'b1;
          state_r <= ST_MULU;
        end
        ST_MULU: state_r <= ST_MULF;
        ST_MULF: state_r <= ST_MULH;
        ST_MULH: state_r <= ST_OUT;
        ST_OUT: if (out_fire) state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_reachable = reach_r;
  assign out_upper_target = ugoal_r;
  assign out_fore_target = fgoal_r;
  assign out_upper_steps = su_r;
  assign out_fore_steps = sf_r;
  assign out_lift_steps = sh_r;
  assign out_committed = commit_r;

  // hold while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_upper_steps))
    else $error("result changed while stalled");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while result pending");
  a_commit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_committed |-> !out_reachable)
    else $error("commit left reach flag set");

endmodule
